FILE: rtl/core/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// Used by the interfaces and by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wbps_pkg;

	// Fixed field widths
	localparam int unsigned PAT_BYTES  = 16;
	localparam int unsigned PAT_LEN_W  = 5;
	localparam int unsigned OFFSET_W   = 32;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 3;

	// Parameter defaults for the top level
	localparam int unsigned DEF_MAX_PATTERN_BYTES = 16;
	localparam int unsigned DEF_ADDRESS_BITS      = 48;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO     = 3'd0,
		REG_PAT_HI     = 3'd1,
		REG_WC_MASK    = 3'd2,
		REG_PAT_LEN    = 3'd3,
		REG_START_ADDR = 3'd4,
		REG_RES_OFFSET = 3'd5
	} cfg_reg_t;

	// Pattern bytes and wildcard bits, byte 0 in the low bits
	typedef struct packed {
		logic [PAT_BYTES*8-1:0] pattern;
		logic [PAT_BYTES-1:0]   wc_mask;
	} pat_cfg_t;

	// Result request passed from the window stage to the output stage
	typedef struct packed {
		logic valid;
		logic found;
	} hit_req_t;

endpackage

FILE: rtl/core/wbps_if.sv
// Stream channels of the scanner: the memory byte channel and the result channel.
// Depends on wbps_pkg for the default address width.
`timescale 1ns / 1ps

interface wbps_in_if
	import wbps_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_readable;
	logic       range_last;

	modport source (output valid, output data_byte, output byte_readable,
		output range_last, input ready);
	modport sink (input valid, input data_byte, input byte_readable,
		input range_last, output ready);
endinterface

interface wbps_out_if
	import wbps_pkg::*;
#(
	parameter int unsigned ADDRESS_BITS = DEF_ADDRESS_BITS
) ();
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic [ADDRESS_BITS-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

FILE: rtl/core/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner.
// Depends on wbps_pkg, wbps_if, wbps_cfg, wbps_window and wbps_result.
//
// Usage:
//  - mem carries one memory byte per request with its readable flag; range_last
//    marks the final byte of a scanned range. A new range starts on the next byte.
//  - result carries at most one request per range: found = 1 with the start
//    address of the first match (result offset added to the low 32 bits), or
//    found = 0 with a zero address when the range ends without a match.
//  - Configuration writes (pattern, wildcard mask, length, start, offset) are taken
//    with cfg_we high, by the user only while no scan is in progress (unchecked).
//  - Throughput: one byte per cycle unless the result path stalls; the window
//    compare covers all pattern bytes in parallel in the cycle the byte is taken.
//  - Result path: the window stage register loads as the byte is taken, and the
//    output register takes the request from it once the output may advance; the
//    result is shown from the output register.
//  - Reset clears the window's readable flags and range state, the registers go
//    to their reset values (length one) and no result is pending.
//  - When the result receiver stalls, the output register holds its result and
//    the window stage still takes bytes until a second result is waiting there.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner
	import wbps_pkg::*;
#(
	parameter int unsigned MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
	parameter int unsigned ADDRESS_BITS      = DEF_ADDRESS_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wbps_in_if.sink               mem,
	wbps_out_if.source            result
);

	localparam int unsigned WIN   = (MAX_PATTERN_BYTES < PAT_BYTES) ?
		MAX_PATTERN_BYTES : PAT_BYTES;
	localparam int unsigned LEN_W = $clog2(WIN + 1);

	pat_cfg_t                pat;
	logic [LEN_W-1:0]        len_m1;
	logic [ADDRESS_BITS-1:0] start_address;
	logic [OFFSET_W-1:0]     result_offset;
	hit_req_t                req_s1;
	logic [ADDRESS_BITS-1:0] base_s1;
	logic                    down_ready;

	// Configuration registers
	wbps_cfg #(
		.WIN    (WIN),
		.ADDR_W (ADDRESS_BITS),
		.LEN_W  (LEN_W)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pat           (pat),
		.len_m1        (len_m1),
		.start_address (start_address),
		.result_offset (result_offset)
	);

	// Window and compare
	wbps_window #(
		.WIN    (WIN),
		.ADDR_W (ADDRESS_BITS),
		.LEN_W  (LEN_W)
	) u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (mem.valid),
		.ready         (mem.ready),
		.data_byte     (mem.data_byte),
		.byte_readable (mem.byte_readable),
		.range_last    (mem.range_last),
		.pat           (pat),
		.len_m1        (len_m1),
		.start_address (start_address),
		.down_ready    (down_ready),
		.req_s1        (req_s1),
		.base_s1       (base_s1)
	);

	// Address adjust and output register
	wbps_result #(
		.ADDR_W (ADDRESS_BITS)
	) u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_s1        (req_s1),
		.base_s1       (base_s1),
		.result_offset (result_offset),
		.down_ready    (down_ready),
		.result        (result)
	);

endmodule

FILE: rtl/core/wbps_cfg.sv
// Configuration registers of the scanner, with the pattern length clamped on write.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_cfg
	import wbps_pkg::*;
#(
	parameter int unsigned WIN    = 16,
	parameter int unsigned ADDR_W = DEF_ADDRESS_BITS,
	parameter int unsigned LEN_W  = $clog2(WIN + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output pat_cfg_t              pat,
	output logic [LEN_W-1:0]      len_m1,
	output logic [ADDR_W-1:0]     start_address,
	output logic [OFFSET_W-1:0]   result_offset
);

	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [PAT_BYTES-1:0]  wc_q;
	logic [LEN_W-1:0]      len_m1_q;
	logic [ADDR_W-1:0]     start_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic [PAT_LEN_W-1:0]  len_wr;
	logic [LEN_W-1:0]      len_m1_wr;

	// Clamp length to 1..WIN, kept as length minus one
	assign len_wr = cfg_data[PAT_LEN_W-1:0];
	always_comb begin
		if (len_wr == '0) begin
			len_m1_wr = '0;
		end else if (len_wr > PAT_LEN_W'(WIN)) begin
			len_m1_wr = LEN_W'(WIN - 1);
		end else begin
			len_m1_wr = LEN_W'(len_wr - PAT_LEN_W'(1));
		end
	end

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wc_q     <= '0;
			len_m1_q <= '0;
			start_q  <= '0;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAT_LO:     pat_lo_q <= cfg_data;
				REG_PAT_HI:     pat_hi_q <= cfg_data;
				REG_WC_MASK:    wc_q     <= cfg_data[PAT_BYTES-1:0];
				REG_PAT_LEN:    len_m1_q <= len_m1_wr;
				REG_START_ADDR: start_q  <= cfg_data[ADDR_W-1:0];
				REG_RES_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pat.pattern    = {pat_hi_q, pat_lo_q};
	assign pat.wc_mask    = wc_q;
	assign len_m1         = len_m1_q;
	assign start_address  = start_q;
	assign result_offset  = offset_q;

endmodule

FILE: rtl/core/wbps_window.sv
// Byte window, parallel pattern compare and range tracking; holds the first stage register.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_window
	import wbps_pkg::*;
#(
	parameter int unsigned WIN    = 16,
	parameter int unsigned ADDR_W = DEF_ADDRESS_BITS,
	parameter int unsigned LEN_W  = $clog2(WIN + 1),
	parameter int unsigned IDX_W  = (WIN > 1) ? $clog2(WIN) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  logic [7:0]        data_byte,
	input  logic              byte_readable,
	input  logic              range_last,
	input  pat_cfg_t          pat,
	input  logic [LEN_W-1:0]  len_m1,
	input  logic [ADDR_W-1:0] start_address,
	input  logic              down_ready,
	output hit_req_t          req_s1,
	output logic [ADDR_W-1:0] base_s1
);

	logic [7:0]        byte_win_q [WIN];
	logic [WIN-1:0]    rd_win_q;
	logic [ADDR_W-1:0] bytes_seen_q;
	logic              match_done_q;

	logic [7:0]        new_byte [WIN];
	logic [WIN-1:0]    new_rd;
	logic [7:0]        pat_b [WIN];
	logic [WIN-1:0]    wc_b;
	logic [WIN-1:0]    ok;
	logic              hit;
	logic              produce;
	logic              accept;
	logic [ADDR_W-1:0] base;

	assign ready  = !req_s1.valid || down_ready;
	assign accept = valid && ready;

	// Window as it stands once the new byte is shifted in
	always_comb begin
		new_byte[0] = data_byte;
		new_rd[0]   = byte_readable;
		for (int i = 1; i < WIN; i++) begin
			new_byte[i] = byte_win_q[i-1];
			new_rd[i]   = rd_win_q[i-1];
		end
	end

	// Pattern bytes in use
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			pat_b[i] = pat.pattern[i*8 +: 8];
			wc_b[i]  = pat.wc_mask[i];
		end
	end

	// Entry w lines up with pattern byte len-1-w; entries past the length pass
	always_comb begin
		logic [IDX_W-1:0] k;
		for (int w = 0; w < WIN; w++) begin
			k     = IDX_W'(len_m1 - LEN_W'(w));
			ok[w] = (LEN_W'(w) > len_m1) ||
				(new_rd[w] && (wc_b[k] || (new_byte[w] == pat_b[k])));
		end
	end

	assign hit     = &ok;
	assign produce = !match_done_q && (hit || range_last);
	assign base    = start_address + bytes_seen_q - ADDR_W'(len_m1);

	// Window contents; only readable flags need clearing at range end
	always_ff @(posedge clk) begin
		if (accept && !match_done_q) begin
			for (int i = 0; i < WIN; i++) begin
				byte_win_q[i] <= new_byte[i];
			end
		end
	end

	// Range tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_win_q     <= '0;
			bytes_seen_q <= '0;
			match_done_q <= 1'b0;
		end else if (accept) begin
			if (range_last) begin
				rd_win_q     <= '0;
				bytes_seen_q <= '0;
				match_done_q <= 1'b0;
			end else if (!match_done_q) begin
				rd_win_q     <= new_rd;
				bytes_seen_q <= bytes_seen_q + ADDR_W'(1);
				match_done_q <= hit;
			end
		end
	end

	// First stage register: a request only for items that give a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (ready) begin
			req_s1.valid <= accept && produce;
			req_s1.found <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1 <= base;
		end
	end

endmodule

FILE: rtl/core/wbps_result.sv
// Output stage: adds the result offset to the low address bits and holds the result.
// Depends on wbps_pkg and the result channel interface.
`timescale 1ns / 1ps

module wbps_result
	import wbps_pkg::*;
#(
	parameter int unsigned ADDR_W = DEF_ADDRESS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hit_req_t            req_s1,
	input  logic [ADDR_W-1:0]   base_s1,
	input  logic [OFFSET_W-1:0] result_offset,
	output logic                down_ready,
	wbps_out_if.source          result
);

	logic                valid_q;
	logic                found_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [OFFSET_W-1:0] low;
	logic                advance;

	assign advance    = !valid_q || result.ready;
	assign down_ready = advance;

	// Offset wraps within the low word; upper bits pass through
	assign low = base_s1[OFFSET_W-1:0] + result_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= req_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_s1.valid) begin
			found_q <= req_s1.found;
			addr_q  <= req_s1.found ? {base_s1[ADDR_W-1:OFFSET_W], low} : '0;
		end
	end

	assign result.valid         = valid_q;
	assign result.found         = found_q;
	assign result.match_address = addr_q;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the wildcard byte pattern scanner: random byte ranges,
// a byte-level predictor of the scan, and result checking against it.
// Depends on wbps_pkg, wbps_if and the wildcard_byte_pattern_scanner top level.
`timescale 1ns / 1ps

module tb;
	import wbps_pkg::*;

	localparam int unsigned MAXB       = DEF_MAX_PATTERN_BYTES;
	localparam int unsigned ADDR_W     = DEF_ADDRESS_BITS;
	localparam int unsigned LEN_CAP    = (MAXB < PAT_BYTES) ? MAXB : PAT_BYTES;
	localparam int unsigned DRAIN_CYC  = 4;
	localparam int unsigned PHASE_REQS = 220;
	localparam int unsigned N_PHASES   = 10;
	localparam int unsigned MAX_REPORT = 10;

	// Register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [7:0] data;
		logic       readable;
		logic       last;
	} mem_req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} scan_hit_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	wbps_in_if                          mem_if ();
	wbps_out_if #(.ADDRESS_BITS(ADDR_W)) res_if ();

	wildcard_byte_pattern_scanner #(
		.MAX_PATTERN_BYTES(MAXB),
		.ADDRESS_BITS(ADDR_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mem(mem_if),
		.result(res_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bench copy of the registers
	bit [63:0]       m_pat_lo;
	bit [63:0]       m_pat_hi;
	bit [15:0]       m_wc;
	bit [4:0]        m_len = 5'd1;
	bit [ADDR_W-1:0] m_start;
	bit [31:0]       m_offset;

	// Bench copy of the scan state
	bit [7:0]        win_data [MAXB];
	bit              win_ok [MAXB];
	bit [ADDR_W-1:0] seen;
	bit              hit_done;

	mem_req_t    byte_q [$];
	scan_hit_t   expected_hits [$];
	int unsigned mismatches;
	int unsigned send_gap;
	int unsigned recv_gap;
	int unsigned queued_reqs;
	bit          no_idle;

	function automatic int unsigned eff_len();
		if (m_len == 0)
			return 1;
		if (m_len > LEN_CAP)
			return LEN_CAP;
		return m_len;
	endfunction

	function automatic logic [7:0] pat_byte(input int unsigned k);
		if (k < 8)
			return m_pat_lo[8*k +: 8];
		return m_pat_hi[8*(k-8) +: 8];
	endfunction

	// One byte in three from the pattern, so short patterns turn up in noise too
	function automatic logic [7:0] rand_byte();
		if ($urandom_range(0, 2) == 0)
			return pat_byte($urandom_range(0, eff_len() - 1));
		return 8'($urandom);
	endfunction

	// Shift one byte into the window and queue the result it causes, if any
	task automatic scan_byte(input mem_req_t req);
		int unsigned     len;
		int unsigned     w;
		bit              hit;
		logic [ADDR_W-1:0] base;
		logic [31:0]     low;
		begin
			if (!hit_done) begin
				len = eff_len();
				for (int i = MAXB - 1; i > 0; i--) begin
					win_data[i] = win_data[i-1];
					win_ok[i]   = win_ok[i-1];
				end
				win_data[0] = req.data;
				win_ok[0]   = req.readable;

				// pattern byte k sits len-1-k places behind the newest byte
				hit = 1'b1;
				for (int k = 0; k < len; k++) begin
					w = len - 1 - k;
					if (!win_ok[w])
						hit = 1'b0;
					else if (!m_wc[k] && win_data[w] != pat_byte(k))
						hit = 1'b0;
				end

				if (hit) begin
					base = m_start + seen - ADDR_W'(len - 1);
					low  = base[31:0] + m_offset;
					expected_hits.push_back('{1'b1, {base[ADDR_W-1:32], low}});
					hit_done = 1'b1;
				end
				seen = seen + 1'b1;

				if (req.last && !hit)
					expected_hits.push_back('{1'b0, '0});
			end

			// end of range: fresh window for the next one
			if (req.last) begin
				for (int i = 0; i < MAXB; i++) begin
					win_data[i] = '0;
					win_ok[i]   = 1'b0;
				end
				seen     = '0;
				hit_done = 1'b0;
			end
		end
	endtask

	task automatic push_byte(input logic [7:0] d, input logic rd, input logic fin);
		byte_q.push_back('{d, rd, fin});
		queued_reqs++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PAT_LO:     m_pat_lo = val;
			REG_PAT_HI:     m_pat_hi = val;
			REG_WC_MASK:    m_wc     = val[15:0];
			REG_PAT_LEN:    m_len    = val[4:0];
			REG_START_ADDR: m_start  = val[ADDR_W-1:0];
			REG_RES_OFFSET: m_offset = val[31:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Block is idle once every request is taken and every result is back,
	// followed by a drain wait for ranges still in flight
	task automatic wait_idle();
		while (byte_q.size() != 0 || expected_hits.size() != 0 || mem_if.valid)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Byte driver: holds a request until taken, random gaps in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (mem_if.valid && mem_if.ready)
				scan_byte(byte_q.pop_front());
			if (!mem_if.valid || mem_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					mem_if.valid <= 1'b0;
				end else if (byte_q.size() == 0) begin
					mem_if.valid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 3);
					mem_if.valid <= 1'b0;
				end else begin
					mem_if.valid         <= 1'b1;
					mem_if.data_byte     <= byte_q[0].data;
					mem_if.byte_readable <= byte_q[0].readable;
					mem_if.range_last    <= byte_q[0].last;
				end
			end
		end
	end

	// Result monitor: compares each taken request with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (expected_hits.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display("unexpected result: found %0b addr %h",
							res_if.found, res_if.match_address);
				end else begin
					if (res_if.found !== expected_hits[0].found ||
						res_if.match_address !== expected_hits[0].addr) begin
						mismatches++;
						if (mismatches <= MAX_REPORT)
							$display("result mismatch: exp found %0b addr %h, got found %0b addr %h",
								expected_hits[0].found, expected_hits[0].addr,
								res_if.found, res_if.match_address);
					end
					void'(expected_hits.pop_front());
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				res_if.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 3);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		int unsigned len;
		int unsigned sel;
		int unsigned kind;
		int unsigned pre;
		int unsigned post;
		int unsigned nb;
		int          corrupt;
		bit          corrupt_rd;
		logic [7:0]  d;
		logic        rd;
		logic [15:0] mask;
		logic [63:0] addr_val;
		logic [63:0] off_val;

		mem_if.valid         = 1'b0;
		mem_if.data_byte     = '0;
		mem_if.byte_readable = 1'b0;
		mem_if.range_last    = 1'b0;
		res_if.ready         = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: length one, pattern byte zero
		push_byte(8'h00, 1'b1, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		wait_idle();

		// '*' and '?' codes as plain bytes, match start wrapping the address,
		// offset wrapping the low word
		write_reg(REG_PAT_LEN, 64'd4);
		write_reg(REG_PAT_LO, 64'h0000_0000_FF00_3F2A);
		write_reg(REG_START_ADDR, 64'h0000_FFFF_FFFF_FFFE);
		write_reg(REG_RES_OFFSET, 64'h0000_0000_FFFF_FFFF);
		push_byte(8'h11, 1'b1, 1'b0);
		push_byte(8'h2A, 1'b1, 1'b0);
		push_byte(8'h3F, 1'b1, 1'b0);
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h2A, 1'b1, 1'b1);
		// unreadable byte inside an otherwise matching window
		push_byte(8'h2A, 1'b1, 1'b0);
		push_byte(8'h3F, 1'b0, 1'b0);
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b1);
		wait_idle();

		// Zero length acts as one
		write_reg(REG_PAT_LEN, 64'd0);
		write_reg(REG_PAT_LO, 64'h0000_0000_0000_003F);
		push_byte(8'h2A, 1'b1, 1'b0);
		push_byte(8'h3F, 1'b1, 1'b1);
		wait_idle();

		// Oversized length clamps to full width, all wildcards, spare indexes ignored
		write_reg(REG_PAT_LEN, 64'd31);
		write_reg(REG_WC_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_START_ADDR, 64'hFFFF_0000_0000_0005);
		write_reg(REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SPARE_7, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < LEN_CAP; i++)
			push_byte(8'($urandom), 1'b1, i == LEN_CAP - 1);
		wait_idle();

		// Random phases, each with its own register set
		for (int ph = 0; ph < N_PHASES; ph++) begin
			no_idle = (ph == N_PHASES - 1);

			sel = $urandom_range(0, 9);
			if (sel <= 5)
				len = $urandom_range(1, 6);
			else if (sel == 6)
				len = LEN_CAP;
			else if (sel == 7)
				len = $urandom_range(7, LEN_CAP - 1);
			else if (sel == 8)
				len = 0;
			else
				len = $urandom_range(LEN_CAP + 1, 31);

			sel = $urandom_range(0, 9);
			if (sel <= 3)
				mask = '0;
			else if (sel <= 7)
				mask = 16'($urandom);
			else if (sel == 8)
				mask = 16'hFFFF;
			else
				mask = 16'(1) << $urandom_range(0, 15);

			sel = $urandom_range(0, 3);
			if (sel == 0)
				addr_val = '0;
			else if (sel == 1)
				addr_val = 64'h0000_FFFF_FFFF_FFFF - $urandom_range(0, 20);
			else if (sel == 2)
				addr_val = {16'($urandom), 16'($urandom), 32'hFFFF_FFF0};
			else
				addr_val = {$urandom, $urandom};

			sel = $urandom_range(0, 3);
			if (sel == 0)
				off_val = '0;
			else if (sel == 1)
				off_val = 64'h0000_0000_FFFF_FFFF;
			else
				off_val = {$urandom, $urandom};

			write_reg(REG_PAT_LO, {$urandom, $urandom});
			write_reg(REG_PAT_HI, {$urandom, $urandom});
			write_reg(REG_WC_MASK, {$urandom, 16'($urandom), mask});
			write_reg(REG_PAT_LEN, {$urandom, 27'($urandom), 5'(len)});
			write_reg(REG_START_ADDR, addr_val);
			write_reg(REG_RES_OFFSET, off_val);
			if (ph % 2 == 1)
				write_reg(REG_SPARE_6, {$urandom, $urandom});

			len = eff_len();
			queued_reqs = 0;
			while (queued_reqs < PHASE_REQS) begin
				kind = $urandom_range(0, 9);
				if (kind <= 5) begin
					// well-formed: noise, pattern (maybe spoilt), noise
					pre  = $urandom_range(0, 6);
					post = $urandom_range(0, 6);
					corrupt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
					corrupt_rd = $urandom_range(0, 1);
					for (int i = 0; i < pre; i++)
						push_byte(rand_byte(), $urandom_range(0, 9) != 0, 1'b0);
					for (int k = 0; k < len; k++) begin
						d  = m_wc[k] ? 8'($urandom) : pat_byte(k);
						rd = 1'b1;
						if (k == corrupt) begin
							if (corrupt_rd)
								rd = 1'b0;
							else
								d = d ^ 8'($urandom_range(1, 255));
						end
						push_byte(d, rd, k == len - 1 && post == 0);
					end
					for (int i = 0; i < post; i++)
						push_byte(rand_byte(), $urandom_range(0, 9) != 0, i == post - 1);
				end else if (kind <= 7) begin
					// plain noise
					nb = $urandom_range(1, 20);
					for (int i = 0; i < nb; i++)
						push_byte(rand_byte(), $urandom_range(0, 9) != 0, i == nb - 1);
				end else if (kind == 8 && len > 1) begin
					// range ends part way through the pattern
					nb = $urandom_range(1, len - 1);
					for (int k = 0; k < nb; k++)
						push_byte(m_wc[k] ? 8'($urandom) : pat_byte(k), 1'b1, k == nb - 1);
				end else begin
					push_byte(rand_byte(), $urandom_range(0, 1), 1'b1);
				end
			end
			wait_idle();
		end

		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && expected_hits.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
